// File: src/led_command_frame_encoder_unit_defines.svh
// Assertion macros for the LED command frame encoder.
`ifndef LED_COMMAND_FRAME_ENCODER_UNIT_DEFINES_SVH
`define LED_COMMAND_FRAME_ENCODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// check held off while reset is active
`define LCFE_ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define LCFE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCFE_ASSERT_RST(name, clk, rst_n, prop, msg)
`define LCFE_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: src/lcfe_pkg.sv
package lcfe_pkg;

  // frame framing bytes
  localparam logic [7:0] SYNC_HI = 8'h7A;
  localparam logic [7:0] SYNC_LO = 8'hA7;
  localparam logic [7:0] TAIL_HI = 8'hD3;
  localparam logic [7:0] TAIL_LO = 8'h3D;

  // request kinds
  localparam logic [3:0] MODE_BAY     = 4'd0;
  localparam logic [3:0] MODE_ALIVE   = 4'd1;
  localparam logic [3:0] MODE_STATE   = 4'd2;
  localparam logic [3:0] MODE_COLOR   = 4'd3;
  localparam logic [3:0] MODE_HEART   = 4'd4;
  localparam logic [3:0] MODE_CALIB   = 4'd5;
  localparam logic [3:0] MODE_COLL    = 4'd6;
  localparam logic [3:0] MODE_VERSION = 4'd7;
  localparam logic [3:0] MODE_CLEAN   = 4'd8;
  localparam logic [3:0] MODE_FACTORY = 4'd9;

  // device command codes
  localparam logic [7:0] CMD_BAY     = 8'h01;
  localparam logic [7:0] CMD_ALIVE   = 8'h12;
  localparam logic [7:0] CMD_STATE   = 8'h02;
  localparam logic [7:0] CMD_COLOR   = 8'h05;
  localparam logic [7:0] CMD_HEART   = 8'h10;
  localparam logic [7:0] CMD_CALIB   = 8'h07;
  localparam logic [7:0] CMD_COLL    = 8'h06;
  localparam logic [7:0] CMD_VERSION = 8'h08;
  localparam logic [7:0] CMD_CLEAN   = 8'h09;
  localparam logic [7:0] CMD_FACTORY = 8'h30;

  localparam logic [7:0] FACTORY_SUM  = 8'h37;
  localparam logic [7:0] FREQ_ANY     = 8'hFF;
  localparam logic [7:0] SEC_MAX      = 8'd59;
  localparam logic [7:0] MIN_MAX      = 8'd27;
  localparam logic [7:0] SEC_MAX_LAST = 8'd57;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned FREQ_SCALE  = 10;

  // sync(2) + len + code + checksum + tail(2)
  localparam int unsigned FRAME_OVERHEAD = 7;
  localparam int unsigned PAY_MAX        = 4;
  localparam int unsigned LEN_W          = 4;

  // descriptor queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                         err;
    logic [LEN_W-1:0]             len;
    logic [7:0]                   code;
    logic [PAY_MAX-1:0][7:0]      pay;
    logic [7:0]                   csum;
  } frame_t;

endpackage

// File: src/lcfe_if.sv
interface lcfe_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [7:0]  buffer_room;
  logic [7:0]  first_arg;
  logic [7:0]  second_arg;
  logic [7:0]  third_arg;
  logic [7:0]  fourth_arg;
  logic [15:0] bay_colors;

  modport source (
    output valid, mode, buffer_room, first_arg, second_arg, third_arg, fourth_arg,
           bay_colors,
    input  ready
  );
  modport sink (
    input  valid, mode, buffer_room, first_arg, second_arg, third_arg, fourth_arg,
           bay_colors,
    output ready
  );
endinterface

interface lcfe_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink (input valid, out_byte, last, error, output ready);
endinterface

// File: src/lcfe_front.sv
module lcfe_front (
  lcfe_req_if.sink        req_i,
  input  logic            q_ready_i,
  output logic            push_o,
  output lcfe_pkg::frame_t desc_o
);
  import lcfe_pkg::*;

  logic [7:0]       a1, a2;
  logic [11:0]      per10;
  logic [15:0]      secs;
  logic [2:0]       npay;
  logic [LEN_W-1:0] len;
  logic             bad;
  logic [7:0]       code;
  logic [PAY_MAX-1:0][7:0] pay;
  logic [7:0]       sum;

  assign req_i.ready = q_ready_i;
  assign push_o      = req_i.valid && q_ready_i;

  assign a1    = req_i.first_arg;
  assign a2    = req_i.second_arg;
  assign per10 = 12'(a2) * 12'(FREQ_SCALE);
  assign secs  = 16'(a1) * 16'(SEC_PER_MIN) + 16'(a2);

  always_comb begin
    bad  = 1'b0;
    code = '0;
    pay  = '0;
    npay = '0;
    unique case (req_i.mode) inside
      MODE_BAY, MODE_ALIVE, MODE_STATE: begin
        code = (req_i.mode == MODE_BAY)   ? CMD_BAY :
               (req_i.mode == MODE_ALIVE) ? CMD_ALIVE : CMD_STATE;
        if (a2 == '0) bad = 1'b1;
        if ((12'(a1) > per10) && (a1 != FREQ_ANY)) bad = 1'b1;
        pay[0] = a1;
        pay[1] = a2;
        npay   = 3'd2;
      end
      MODE_COLOR: begin
        code = CMD_COLOR;
        for (int i = 0; i < 8; i++) begin
          if (req_i.bay_colors[2*i +: 2] == 2'b11) bad = 1'b1;
        end
        pay[0] = req_i.bay_colors[7:0];
        pay[1] = req_i.bay_colors[15:8];
        pay[2] = a1;
        npay   = 3'd3;
      end
      MODE_HEART: begin
        code = CMD_HEART;
        if ((a1 >= MIN_MAX) && (a2 > SEC_MAX_LAST)) bad = 1'b1;
        if (a2 > SEC_MAX) bad = 1'b1;
        if (a1 > MIN_MAX) bad = 1'b1;
        pay[0] = secs[15:8];
        pay[1] = secs[7:0];
        npay   = 3'd2;
      end
      MODE_CALIB:   code = CMD_CALIB;
      MODE_COLL: begin
        code   = CMD_COLL;
        pay[0] = a1;
        pay[1] = a2;
        pay[2] = req_i.third_arg;
        pay[3] = req_i.fourth_arg;
        npay   = 3'd4;
      end
      MODE_VERSION: code = CMD_VERSION;
      MODE_CLEAN:   code = CMD_CLEAN;
      MODE_FACTORY: code = CMD_FACTORY;
      default:      bad  = 1'b1;
    endcase
  end

  assign len = LEN_W'(FRAME_OVERHEAD) + LEN_W'(npay);

  // unused payload slots are zero, so all four go into the sum
  assign sum = (req_i.mode == MODE_FACTORY) ? FACTORY_SUM :
               8'(len) + code + pay[0] + pay[1] + pay[2] + pay[3];

  always_comb begin
    desc_o      = '0;
    desc_o.err  = bad || (req_i.buffer_room < 8'(len));
    desc_o.len  = len;
    desc_o.code = code;
    desc_o.pay  = pay;
    desc_o.csum = sum;
  end

endmodule

// File: src/lcfe_fifo.sv
module lcfe_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lcfe_pkg::frame_t push_desc_i,
  output logic             ready_o,
  output logic             valid_o,
  output lcfe_pkg::frame_t head_o,
  input  logic             pop_i
);
  import lcfe_pkg::*;

  frame_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_desc_i;
  end

endmodule

// File: src/lcfe_back.sv
module lcfe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  lcfe_pkg::frame_t head_i,
  output logic             pop_o,
  lcfe_rsp_if.source       rsp_o
);
  import lcfe_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_err_q, out_err_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] rel, npay;
  logic [7:0]       sel_byte;
  logic             is_last, load;

  assign npay = head_i.len - LEN_W'(FRAME_OVERHEAD);
  assign rel  = idx_q - LEN_W'(4);

  always_comb begin
    case (idx_q)
      LEN_W'(0): sel_byte = SYNC_HI;
      LEN_W'(1): sel_byte = SYNC_LO;
      LEN_W'(2): sel_byte = 8'(head_i.len);
      LEN_W'(3): sel_byte = head_i.code;
      default: begin
        if (rel < npay)                     sel_byte = head_i.pay[rel[1:0]];
        else if (rel == npay)               sel_byte = head_i.csum;
        else if (rel == npay + LEN_W'(1))   sel_byte = TAIL_HI;
        else                                sel_byte = TAIL_LO;
      end
    endcase
  end

  assign is_last = head_i.err || (idx_q == head_i.len - LEN_W'(1));
  assign load    = !out_valid_q || rsp_o.ready;
  assign pop_o   = load && q_valid_i && is_last;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = q_valid_i;
      if (q_valid_i) begin
        out_byte_d = head_i.err ? 8'h00 : sel_byte;
        out_last_d = is_last;
        out_err_d  = head_i.err;
        idx_d      = is_last ? '0 : idx_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.out_byte = out_byte_q;
  assign rsp_o.last     = out_last_q;
  assign rsp_o.error    = out_err_q;

endmodule

// File: src/led_command_frame_encoder_unit.sv
// LED command frame encoder.
// req_i: one beat is one command request (mode, buffer_room, args, bay_colors).
// rsp_o: one beat is one frame byte; last marks the final byte of a frame.
//   A request that fails its checks gives one beat with error=1, last=1,
//   out_byte=0 and no frame.
// Frames are 7 to 11 bytes: 7A A7, length, code, payload, checksum, D3 3D.
// The first byte of a request's result goes through the queue write, then the
//   output register, before it is presented on rsp_o.
// Throughput: one result beat per cycle while rsp ready is high; a request costs
//   a beat per frame byte (one for an error); the back-end sequencer sets this.
// Requests are decoded on acceptance and wait as descriptors in a 2-entry
//   queue, so new requests are taken while a frame is still streaming out.
// Reset clears the queue and the output register; no frame is in flight after.
// When the receiver holds rsp ready low, the byte on rsp_o is held, the
//   sequencer stops, and req ready falls once the queue is full.
`include "led_command_frame_encoder_unit_defines.svh"

module led_command_frame_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcfe_req_if.sink    req_i,
  lcfe_rsp_if.source  rsp_o
);
  import lcfe_pkg::*;

  // front -> queue
  frame_t push_desc;
  logic   q_push;
  logic   q_ready;
  // queue -> back
  frame_t q_head;
  logic   q_valid;
  logic   q_pop;

  // decode and check the request, build the frame descriptor
  lcfe_front u_front (
    .req_i     (req_i),
    .q_ready_i (q_ready),
    .push_o    (q_push),
    .desc_o    (push_desc)
  );

  // short descriptor queue decoupling request intake from byte output
  lcfe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  // byte sequencer with registered output
  lcfe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .rsp_o     (rsp_o)
  );

  // a descriptor must not retire while its last beat is still stalled
  `LCFE_ASSERT_RST(a_no_pop_on_stall, clk_i, rst_ni, (rsp_o.valid && !rsp_o.ready) |-> !q_pop, "queue popped during output stall")
  // an error result is one zero beat that closes the request
  `LCFE_ASSERT_RST(a_err_beat, clk_i, rst_ni, (rsp_o.valid && rsp_o.error) |-> (rsp_o.last && rsp_o.out_byte == 8'h00), "malformed error beat")
  // every good frame ends with the closing tail byte
  `LCFE_ASSERT_RST(a_frame_tail, clk_i, rst_ni, (rsp_o.valid && rsp_o.last && !rsp_o.error) |-> (rsp_o.out_byte == TAIL_LO), "frame does not end in tail byte")

endmodule

// File: tb/sv/tb_led_command_frame_encoder_unit.sv
module tb_led_command_frame_encoder_unit;
  import lcfe_pkg::*;

  // mode values with no command behind them
  localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

  localparam int unsigned FRAME_MAX    = FRAME_OVERHEAD + PAY_MAX;
  localparam int unsigned RANDOM_REQS  = 300;
  localparam int unsigned BURST_REQS   = 20;
  localparam int unsigned LONG_HOLD    = 400;  // receiver hold-off, in cycles
  localparam int unsigned TAIL_CYCLES  = 30;   // quiet time after the last byte
  localparam int unsigned MAX_REPORTED = 10;
  // worst case: every request an 11-byte frame, every byte behind the longest stall,
  // every request behind the longest gap, then taken about five times over
  localparam longint unsigned RUN_LIMIT = 64'd12_000_000;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  buffer_room;
    logic [7:0]  first_arg;
    logic [7:0]  second_arg;
    logic [7:0]  third_arg;
    logic [7:0]  fourth_arg;
    logic [15:0] bay_colors;
  } cmd_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } frame_beat_t;

  // Holds the frame bytes still owed by the block, in order, and checks each
  // byte beat that comes out against the oldest one.
  class frame_scoreboard;
    frame_beat_t owed_beats[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    // Encode one accepted request into the frame (or error beat) it must give.
    function void note_request(cmd_req_t r);
      logic [7:0]  pay [PAY_MAX];
      logic [7:0]  frame_bytes [FRAME_MAX];
      logic [7:0]  code;
      logic [7:0]  csum;
      logic [15:0] secs;
      int unsigned npay;
      int unsigned flen;
      bit          bad;
      bad  = 1'b0;
      npay = 0;
      code = 8'h00;
      secs = 16'h0000;
      foreach (pay[i]) pay[i] = 8'h00;
      case (r.mode)
        MODE_BAY, MODE_ALIVE, MODE_STATE: begin
          code = (r.mode == MODE_BAY) ? CMD_BAY :
                 (r.mode == MODE_ALIVE) ? CMD_ALIVE : CMD_STATE;
          if (r.second_arg == 8'd0) bad = 1'b1;
          if (32'(r.first_arg) > 32'(r.second_arg) * FREQ_SCALE &&
              r.first_arg != FREQ_ANY) bad = 1'b1;
          pay[0] = r.first_arg;
          pay[1] = r.second_arg;
          npay = 2;
        end
        MODE_COLOR: begin
          code = CMD_COLOR;
          for (int i = 0; i < 8; i++)
            if (r.bay_colors[2*i +: 2] == 2'd3) bad = 1'b1;
          pay[0] = r.bay_colors[7:0];
          pay[1] = r.bay_colors[15:8];
          pay[2] = r.first_arg;
          npay = 3;
        end
        MODE_HEART: begin
          code = CMD_HEART;
          if (r.first_arg >= MIN_MAX && r.second_arg > SEC_MAX_LAST) bad = 1'b1;
          if (r.second_arg > SEC_MAX) bad = 1'b1;
          if (r.first_arg > MIN_MAX) bad = 1'b1;
          secs = 16'(32'(r.first_arg) * SEC_PER_MIN + 32'(r.second_arg));
          pay[0] = secs[15:8];
          pay[1] = secs[7:0];
          npay = 2;
        end
        MODE_CALIB:   code = CMD_CALIB;
        MODE_COLL: begin
          code = CMD_COLL;
          pay[0] = r.first_arg;
          pay[1] = r.second_arg;
          pay[2] = r.third_arg;
          pay[3] = r.fourth_arg;
          npay = 4;
        end
        MODE_VERSION: code = CMD_VERSION;
        MODE_CLEAN:   code = CMD_CLEAN;
        MODE_FACTORY: code = CMD_FACTORY;
        default:      bad = 1'b1;
      endcase
      flen = FRAME_OVERHEAD + npay;
      if (32'(r.buffer_room) < flen) bad = 1'b1;
      if (bad) begin
        owed_beats.push_back('{out_byte: 8'h00, last: 1'b1, error: 1'b1});
        return;
      end
      csum = 8'(flen) + code;
      for (int i = 0; i < npay; i++) csum += pay[i];
      if (r.mode == MODE_FACTORY) csum = FACTORY_SUM;
      frame_bytes[0] = SYNC_HI;
      frame_bytes[1] = SYNC_LO;
      frame_bytes[2] = 8'(flen);
      frame_bytes[3] = code;
      for (int i = 0; i < npay; i++) frame_bytes[4 + i] = pay[i];
      frame_bytes[4 + npay] = csum;
      frame_bytes[5 + npay] = TAIL_HI;
      frame_bytes[6 + npay] = TAIL_LO;
      for (int i = 0; i < flen; i++)
        owed_beats.push_back('{out_byte: frame_bytes[i], last: (i + 1 == flen),
                               error: 1'b0});
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t want;
      if (owed_beats.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTED)
          $display("%0t: unexpected beat byte=%h last=%b error=%b",
                   $time, got.out_byte, got.last, got.error);
        return;
      end
      want = owed_beats.pop_front();
      if (got.out_byte !== want.out_byte || got.last !== want.last ||
          got.error !== want.error) begin
        failures++;
        if (failures <= MAX_REPORTED)
          $display("%0t: beat mismatch exp byte=%h last=%b error=%b, got byte=%h last=%b error=%b",
                   $time, want.out_byte, want.last, want.error,
                   got.out_byte, got.last, got.error);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lcfe_req_if req_if ();
  lcfe_rsp_if rsp_if ();

  led_command_frame_encoder_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  frame_scoreboard sb;

  // Handshake between the stimulus and the receiver for the one long hold-off:
  // the stimulus raises the request, the receiver marks it taken.
  bit want_long_hold;
  bit long_hold_taken;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit, independent of everything else.
  initial begin
    #(RUN_LIMIT);
    $display("tb_led_command_frame_encoder_unit NOT OK");
    $finish;
  end

  // Gap length: mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic cmd_req_t mk_req(logic [3:0] kind, logic [7:0] room,
                                      logic [7:0] a1, logic [7:0] a2,
                                      logic [7:0] a3, logic [7:0] a4,
                                      logic [15:0] bays);
    cmd_req_t r;
    r.mode        = kind;
    r.buffer_room = room;
    r.first_arg   = a1;
    r.second_arg  = a2;
    r.third_arg   = a3;
    r.fourth_arg  = a4;
    r.bay_colors  = bays;
    return r;
  endfunction

  // Random request. Most are well-formed so they get past the checks and
  // make full frames; the rest are raw noise, which covers unused modes,
  // bad args and short buffers.
  function automatic cmd_req_t random_request();
    cmd_req_t    r;
    int unsigned cap;
    r = cmd_req_t'(60'({$urandom, $urandom}));
    if ($urandom_range(0, 99) < 20) return r;
    r.mode = 4'($urandom_range(MODE_BAY, MODE_FACTORY));
    if ($urandom_range(0, 9) != 0)
      r.buffer_room = 8'($urandom_range(FRAME_MAX, 255));
    case (r.mode)
      MODE_BAY, MODE_ALIVE, MODE_STATE: begin
        r.second_arg = 8'($urandom_range(1, 255));
        cap = 32'(r.second_arg) * FREQ_SCALE;
        if (cap > 255) cap = 255;
        r.first_arg = ($urandom_range(0, 3) == 0) ? FREQ_ANY
                                                 : 8'($urandom_range(0, cap));
      end
      MODE_COLOR:
        for (int i = 0; i < 8; i++) r.bay_colors[2*i +: 2] = 2'($urandom_range(0, 2));
      MODE_HEART: begin
        r.first_arg  = 8'($urandom_range(0, MIN_MAX));
        r.second_arg = 8'($urandom_range(0, (r.first_arg == MIN_MAX) ? SEC_MAX_LAST
                                                                      : SEC_MAX));
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request and hold it until taken, then note it.
  // Called in the time step of a rising edge; returns in one as well.
  // With gap 0 the next request follows in the same step without dropping valid.
  task automatic send_request(cmd_req_t r, int unsigned gap);
    req_if.valid       <= 1'b1;
    req_if.mode        <= r.mode;
    req_if.buffer_room <= r.buffer_room;
    req_if.first_arg   <= r.first_arg;
    req_if.second_arg  <= r.second_arg;
    req_if.third_arg   <= r.third_arg;
    req_if.fourth_arg  <= r.fourth_arg;
    req_if.bay_colors  <= r.bay_colors;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender pause until every owed beat has come out.
  task automatic wait_frames_done();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Stimulus: reset, directed corner requests, then the random run.
  initial begin
    cmd_req_t    directed_reqs[$];
    bit          steady_tx;
    int unsigned gap;
    sb = new();
    want_long_hold     = 1'b0;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_BAY;
    req_if.buffer_room = 8'h00;
    req_if.first_arg   = 8'h00;
    req_if.second_arg  = 8'h00;
    req_if.third_arg   = 8'h00;
    req_if.fourth_arg  = 8'h00;
    req_if.bay_colors  = 16'h0000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blink: freq exactly ten times period passes, one above fails
    directed_reqs.push_back(mk_req(MODE_BAY, 8'd9, 8'd10, 8'd1, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_BAY, 8'd9, 8'd11, 8'd1, 8'h00, 8'h00, 16'h0000));
    // free-running freq ignores the ratio, but not a zero period
    directed_reqs.push_back(mk_req(MODE_ALIVE, 8'd9, FREQ_ANY, 8'd1, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_STATE, 8'hFF, FREQ_ANY, 8'd0, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_STATE, 8'hFF, 8'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    // colour: all code 2, then an invalid code at the top and bottom bay
    directed_reqs.push_back(mk_req(MODE_COLOR, 8'd10, 8'hFF, 8'h00, 8'h00, 8'h00, 16'hAAAA));
    directed_reqs.push_back(mk_req(MODE_COLOR, 8'd10, 8'h00, 8'h00, 8'h00, 8'h00, 16'hC000));
    directed_reqs.push_back(mk_req(MODE_COLOR, 8'd10, 8'h5A, 8'h00, 8'h00, 8'h00, 16'h0003));
    directed_reqs.push_back(mk_req(MODE_COLOR, 8'd9, 8'h00, 8'h00, 8'h00, 8'h00, 16'h5555));
    // heartbeat limits around 27:57
    directed_reqs.push_back(mk_req(MODE_HEART, 8'd9, 8'd27, 8'd57, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_HEART, 8'd9, 8'd27, 8'd58, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_HEART, 8'd9, 8'd26, 8'd59, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_HEART, 8'd9, 8'd0, 8'd60, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_HEART, 8'd9, 8'd28, 8'd0, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_HEART, 8'd9, 8'd0, 8'd0, 8'h00, 8'h00, 16'h0000));
    // payload-free commands at and below the minimum room
    directed_reqs.push_back(mk_req(MODE_CALIB, 8'd7, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_CALIB, 8'd6, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_COLL, 8'd11, 8'hFF, 8'h00, 8'hAA, 8'h55, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_COLL, 8'd10, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_VERSION, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_VERSION, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_CLEAN, 8'd7, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    // factory test: fixed checksum
    directed_reqs.push_back(mk_req(MODE_FACTORY, 8'd7, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_UNUSED_LO, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    directed_reqs.push_back(mk_req(MODE_UNUSED_HI, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));

    foreach (directed_reqs[i]) send_request(directed_reqs[i], pick_gap());
    send_request(random_request(), 1);
    wait_frames_done();

    steady_tx = 1'b0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) steady_tx = ($urandom_range(0, 2) == 0);
      if (n == 100) begin
        // back-to-back burst into a receiver that stops taking bytes:
        // the descriptor queue fills and req ready must drop
        want_long_hold = 1'b1;
        for (int k = 0; k < BURST_REQS; k++) send_request(random_request(), 0);
      end
      if (n == 200) begin
        send_request(random_request(), 1);
        wait_frames_done();
      end
      gap = steady_tx ? 0 : pick_gap();
      send_request(random_request(), (n + 1 == RANDOM_REQS) ? 1 : gap);
    end

    wait_frames_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_led_command_frame_encoder_unit OK");
    end else begin
      $display("tb_led_command_frame_encoder_unit NOT OK");
    end
    $finish;
  end

  // Receiver: random stalls, short mostly and a few long, with stretches of
  // no stalls at all, plus one long hold-off on request from the stimulus.
  initial begin
    int unsigned stall_left;
    int unsigned seg_left;
    bit          steady_rx;
    rsp_if.ready = 1'b0;
    long_hold_taken = 1'b0;
    stall_left = 0;
    seg_left   = 0;
    steady_rx  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (want_long_hold && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        seg_left  = $urandom_range(30, 150);
        steady_rx = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!steady_rx && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 2);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Byte beats leaving the block, sampled at the edge that takes them.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_beat('{out_byte: rsp_if.out_byte, last: rsp_if.last, error: rsp_if.error});
  end

endmodule
